// ----- design/rgbhsl_pkg.sv -----
package rgbhsl_pkg;

    // channel range
    localparam int CH_W      = 6;
    localparam int CH_MAX    = 63;
    localparam int TWO_CH    = 2 * CH_MAX;
    localparam int CH_TOP    = (1 << CH_W) - 1;
    localparam int SUM_W     = CH_W + 1;
    localparam int SUM_MAX   = 2 * CH_TOP;

    // result fields
    localparam int HUE_W     = 9;
    localparam int SAT_W     = 7;
    localparam int LIT_W     = 7;
    localparam int PCT_MAX   = 100;
    localparam int PCT_HALF  = 50;
    localparam int DEG_FULL  = 360;
    localparam int DEG_GREEN = 120;
    localparam int DEG_BLUE  = 240;
    localparam int DEG_SECT  = 60;

    // stream widths
    localparam int IN_TDATA_W  = ((3 * CH_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((HUE_W + SAT_W + LIT_W + 7) / 8) * 8;

    // lightness: sum * 100 / (2 * CH_MAX) by reciprocal multiply
    localparam int    L_SH     = 23;
    localparam longint L_RECIP = ((longint'(1) << L_SH) + TWO_CH - 1) / TWO_CH;
    localparam longint L_MUL   = L_RECIP * PCT_MAX;
    localparam int    LM_W     = $clog2(L_MUL + 1);
    localparam int    LPROD_W  = SUM_W + LM_W;
    localparam int    LRAW_W   = $clog2(SUM_MAX * PCT_MAX / TWO_CH + 1);

    // divider operands
    localparam int QUO_W   = 7;
    localparam int QB_W    = $clog2(QUO_W);
    localparam int DEN_RAW = $clog2(TWO_CH + 1);
    localparam int DEN_W   = (DEN_RAW > SUM_W) ? DEN_RAW : SUM_W;
    localparam int SNUM_W  = $clog2(CH_TOP * PCT_MAX + 1);
    localparam int HNUM_W  = $clog2(CH_TOP * DEG_SECT + 1);
    localparam int SDIV_W  = (SNUM_W > DEN_W + QUO_W - 1) ? SNUM_W : DEN_W + QUO_W - 1;
    localparam int HDIV_W  = (HNUM_W > CH_W + QUO_W - 1) ? HNUM_W : CH_W + QUO_W - 1;
    localparam int OVF_K   = PCT_MAX + 1;
    localparam int OVF_RAW = DEN_W + $clog2(OVF_K + 1);
    localparam int OVF_W   = (OVF_RAW > SNUM_W) ? OVF_RAW : SNUM_W;

    // pipeline depth
    localparam int FRONT_STG = 3;
    localparam int N_STG     = FRONT_STG + QUO_W + 1;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // partial remainders and quotients of both divisions
    typedef struct packed {
        logic [SNUM_W-1:0] snum;
        logic [DEN_W-1:0]  sden;
        logic [QUO_W-1:0]  squo;
        logic [HNUM_W-1:0] hnum;
        logic [CH_W-1:0]   hden;
        logic [QUO_W-1:0]  hquo;
    } t_div;

    // fields carried alongside the divider
    typedef struct packed {
        logic             gray;
        logic             ovf;
        logic             hneg;
        t_sector          sec;
        logic [LIT_W-1:0] light;
    } t_side;

endpackage

// ----- design/rgbhsl_front.sv -----
module rgbhsl_front (
    input  logic                                i_clk,
    input  logic [rgbhsl_pkg::FRONT_STG-1:0]    i_ld,
    input  logic [rgbhsl_pkg::CH_W-1:0]         i_red,
    input  logic [rgbhsl_pkg::CH_W-1:0]         i_green,
    input  logic [rgbhsl_pkg::CH_W-1:0]         i_blue,
    output rgbhsl_pkg::t_div                    o_div,
    output rgbhsl_pkg::t_side                   o_side
);
    import rgbhsl_pkg::*;

    // stage 1 registers
    logic [CH_W-1:0]        r_mx, r_mn, n_mx, n_mn;
    t_sector                r_sec1, n_sec1;
    logic signed [CH_W:0]   r_diff, n_diff;

    // stage 2 registers
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [CH_W-1:0]        r_delta, n_delta;
    logic [LPROD_W-1:0]     r_lprod, n_lprod;
    logic                   r_hneg2, n_hneg2;
    logic [HNUM_W-1:0]      r_hnum2, n_hnum2;
    t_sector                r_sec2;

    // stage 3 registers
    t_div                   r_div, n_div;
    t_side                  r_side, n_side;

    // stage 2 and stage 3 working signals
    logic [CH_W-1:0]        mag;
    logic [LRAW_W-1:0]      l_raw;
    logic                   l_lo;
    logic [DEN_W-1:0]       den;
    logic                   den_np;
    logic [SNUM_W-1:0]      snum;

    // max, min and the channel that leads the hue
    always_comb begin
        n_mx = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx) n_mx = i_blue;
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn) n_mn = i_blue;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sec1 = SEC_RED;
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_sec1 = SEC_GREEN;
            n_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sec1 = SEC_BLUE;
            n_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_mx   <= n_mx;
            r_mn   <= n_mn;
            r_sec1 <= n_sec1;
            r_diff <= n_diff;
        end
    end

    // sum, spread, lightness product and hue numerator magnitude
    always_comb begin
        n_sum   = SUM_W'(r_mx) + SUM_W'(r_mn);
        n_delta = r_mx - r_mn;
        n_lprod = LPROD_W'(n_sum) * LPROD_W'(L_MUL);
        n_hneg2 = r_diff[CH_W];
        mag     = n_hneg2 ? CH_W'(-r_diff) : CH_W'(r_diff);
        n_hnum2 = HNUM_W'(mag) * HNUM_W'(DEG_SECT);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_sum   <= n_sum;
            r_delta <= n_delta;
            r_lprod <= n_lprod;
            r_hneg2 <= n_hneg2;
            r_hnum2 <= n_hnum2;
            r_sec2  <= r_sec1;
        end
    end

    // lightness, saturation divisor and overflow check
    always_comb begin
        l_raw  = r_lprod[L_SH +: LRAW_W];
        l_lo   = (l_raw < LRAW_W'(PCT_HALF));
        den_np = !l_lo && (DEN_W'(r_sum) >= DEN_W'(TWO_CH));
        den    = l_lo ? DEN_W'(r_sum) : DEN_W'(TWO_CH) - DEN_W'(r_sum);
        snum   = SNUM_W'(r_delta) * SNUM_W'(PCT_MAX);

        n_div.snum = snum;
        n_div.sden = den;
        n_div.squo = '0;
        n_div.hnum = r_hnum2;
        n_div.hden = r_delta;
        n_div.hquo = '0;

        n_side.gray  = (r_delta == '0);
        n_side.ovf   = den_np || (OVF_W'(snum) >= OVF_W'(den) * OVF_W'(OVF_K));
        n_side.hneg  = r_hneg2;
        n_side.sec   = r_sec2;
        n_side.light = (l_raw > LRAW_W'(PCT_MAX)) ? LIT_W'(PCT_MAX) : LIT_W'(l_raw);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r_div  <= n_div;
            r_side <= n_side;
        end
    end

    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

// ----- design/rgbhsl_div_step.sv -----
module rgbhsl_div_step (
    input  logic                         i_clk,
    input  logic                         i_ld,
    input  logic [rgbhsl_pkg::QB_W-1:0]  i_bit,
    input  rgbhsl_pkg::t_div             i_div,
    input  rgbhsl_pkg::t_side            i_side,
    output rgbhsl_pkg::t_div             o_div,
    output rgbhsl_pkg::t_side            o_side
);
    import rgbhsl_pkg::*;

    t_div               r_div, n_div;
    t_side              r_side;
    logic [SDIV_W-1:0]  s_sh;
    logic [HDIV_W-1:0]  h_sh;
    logic [QUO_W-1:0]   qbit;

    // one restoring step for saturation and hue quotients
    always_comb begin
        n_div = i_div;
        s_sh  = SDIV_W'(i_div.sden) << i_bit;
        h_sh  = HDIV_W'(i_div.hden) << i_bit;
        qbit  = QUO_W'(1) << i_bit;
        if (SDIV_W'(i_div.snum) >= s_sh) begin
            n_div.snum = SNUM_W'(SDIV_W'(i_div.snum) - s_sh);
            n_div.squo = i_div.squo | qbit;
        end
        if (HDIV_W'(i_div.hnum) >= h_sh) begin
            n_div.hnum = HNUM_W'(HDIV_W'(i_div.hnum) - h_sh);
            n_div.hquo = i_div.hquo | qbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

// ----- design/rgbhsl_back.sv -----
module rgbhsl_back (
    input  logic                          i_clk,
    input  logic                          i_ld,
    input  rgbhsl_pkg::t_div              i_div,
    input  rgbhsl_pkg::t_side             i_side,
    output logic [rgbhsl_pkg::HUE_W-1:0]  o_hue,
    output logic [rgbhsl_pkg::SAT_W-1:0]  o_sat,
    output logic [rgbhsl_pkg::LIT_W-1:0]  o_light
);
    import rgbhsl_pkg::*;

    logic [HUE_W-1:0] r_hue, n_hue;
    logic [SAT_W-1:0] r_sat, n_sat;
    logic [LIT_W-1:0] r_light;
    logic [HUE_W-1:0] q_h;

    // hue offset by sector, saturation clamp, gray override
    always_comb begin
        q_h = HUE_W'(i_div.hquo);
        case (i_side.sec)
            SEC_RED: begin
                n_hue = (i_side.hneg && q_h != '0) ? HUE_W'(DEG_FULL) - q_h : q_h;
            end
            SEC_GREEN: begin
                n_hue = i_side.hneg ? HUE_W'(DEG_GREEN) - q_h : HUE_W'(DEG_GREEN) + q_h;
            end
            SEC_BLUE: begin
                n_hue = i_side.hneg ? HUE_W'(DEG_BLUE) - q_h : HUE_W'(DEG_BLUE) + q_h;
            end
            default: begin
                n_hue = '0;
            end
        endcase
        if (i_side.ovf || i_div.squo > QUO_W'(PCT_MAX)) begin
            n_sat = SAT_W'(PCT_MAX);
        end else begin
            n_sat = SAT_W'(i_div.squo);
        end
        if (i_side.gray) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_light <= i_side.light;
        end
    end

    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_light = r_light;

endmodule

// ----- design/rgb6_to_hsl_converter_unit.sv -----
// channel    | dir | tdata fields (low bit first)
// s_axis     | in  | red[5:0], green[11:6], blue[17:12], zero pad to 24
// m_axis     | out | hue[8:0], saturation[15:9], lightness[22:16], zero pad to 24
//
// eleven register stages: three front stages (max/min, lightness multiply,
// saturation divisor), seven restoring divider steps, one output stage
// one transaction per clock in and out while the output is not stalled
// each stage has its own valid bit; a stalled stage holds while empty stages
// upstream of it keep filling, so bubbles are squeezed out
// synchronous active-low reset clears the valid bits only
module rgb6_to_hsl_converter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // red, green, blue
    input  logic [rgbhsl_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // hue, saturation, lightness
    output logic [rgbhsl_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import rgbhsl_pkg::*;

    logic [N_STG-1:0]  r_vld;
    logic [N_STG-1:0]  ld;
    t_div              div_chain  [0:QUO_W];
    t_side             side_chain [0:QUO_W];
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  sat;
    logic [LIT_W-1:0]  light;

    // stage load enables, from the output back to the input
    always_comb begin
        ld[N_STG-1] = !r_vld[N_STG-1] || i_m_axis_tready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N_STG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_axis_tvalid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_ld    (ld[FRONT_STG-1:0]),
        .i_red   (i_s_axis_tdata[CH_W-1:0]),
        .i_green (i_s_axis_tdata[2*CH_W-1:CH_W]),
        .i_blue  (i_s_axis_tdata[3*CH_W-1:2*CH_W]),
        .o_div   (div_chain[0]),
        .o_side  (side_chain[0])
    );

    // divider steps, most significant quotient bit first
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        rgbhsl_div_step u_step (
            .i_clk  (i_clk),
            .i_ld   (ld[FRONT_STG+j]),
            .i_bit  (QB_W'(QUO_W - 1 - j)),
            .i_div  (div_chain[j]),
            .i_side (side_chain[j]),
            .o_div  (div_chain[j+1]),
            .o_side (side_chain[j+1])
        );
    end

    rgbhsl_back u_back (
        .i_clk   (i_clk),
        .i_ld    (ld[N_STG-1]),
        .i_div   (div_chain[QUO_W]),
        .i_side  (side_chain[QUO_W]),
        .o_hue   (hue),
        .o_sat   (sat),
        .o_light (light)
    );

    assign o_s_axis_tready = ld[0];
    assign o_m_axis_tvalid = r_vld[N_STG-1];
    assign o_m_axis_tdata  = OUT_TDATA_W'({light, sat, hue});

endmodule

// ----- verif/rgb6_to_hsl_converter_unit_test.sv -----
module rgb6_to_hsl_converter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbhsl_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [LIT_W-1:0] light;
    } t_hsl;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // red, green, blue
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // hue, saturation, lightness
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_hsl hsl_expected_q[$];
    int   mismatch_count = 0;
    bit   no_idle = 1'b0;

    rgb6_to_hsl_converter_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the stream hangs
    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // integer hsl of one color, truncating divisions
    function automatic t_hsl predict_hsl(input logic [CH_W-1:0] r, g, b);
        int   red, grn, blu, mx, mn, delta, sum, l, s, h, den;
        t_hsl res;
        red = int'(r);
        grn = int'(g);
        blu = int'(b);
        mx = red;
        if (grn > mx) mx = grn;
        if (blu > mx) mx = blu;
        mn = red;
        if (grn < mn) mn = grn;
        if (blu < mn) mn = blu;
        sum   = mx + mn;
        delta = mx - mn;
        l     = (sum * PCT_MAX) / TWO_CH;
        if (delta == 0) begin
            h = 0;
            s = 0;
        end else begin
            // divisor switches at half lightness
            if (l < PCT_HALF) begin
                s = (delta * PCT_MAX) / sum;
            end else begin
                den = TWO_CH - sum;
                s = (den <= 0) ? PCT_MAX : (delta * PCT_MAX) / den;
            end
            if (s > PCT_MAX) s = PCT_MAX;
            // red wins ties, then green
            if (mx == red) begin
                h = ((grn - blu) * DEG_SECT) / delta;
                if (h < 0) h += DEG_FULL;
            end else if (mx == grn) begin
                h = ((blu - red) * DEG_SECT) / delta + DEG_GREEN;
            end else begin
                h = ((red - grn) * DEG_SECT) / delta + DEG_BLUE;
            end
        end
        if (l > PCT_MAX) l = PCT_MAX;
        res.hue   = h[HUE_W-1:0];
        res.sat   = s[SAT_W-1:0];
        res.light = l[LIT_W-1:0];
        return res;
    endfunction

    // scoreboard: check results, then record accepted pixels
    always @(posedge i_clk) begin
        t_hsl got;
        t_hsl want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.hue   = o_m_axis_tdata[HUE_W-1:0];
                got.sat   = o_m_axis_tdata[HUE_W+SAT_W-1:HUE_W];
                got.light = o_m_axis_tdata[HUE_W+SAT_W+LIT_W-1:HUE_W+SAT_W];
                if (hsl_expected_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual h=%0d s=%0d l=%0d",
                             $time, got.hue, got.sat, got.light);
                end else begin
                    want = hsl_expected_q.pop_front();
                    if (got.hue !== want.hue) begin
                        mismatch_count++;
                        $display("%0t: hue mismatch, expected %0d, actual %0d",
                                 $time, want.hue, got.hue);
                    end
                    if (got.sat !== want.sat) begin
                        mismatch_count++;
                        $display("%0t: saturation mismatch, expected %0d, actual %0d",
                                 $time, want.sat, got.sat);
                    end
                    if (got.light !== want.light) begin
                        mismatch_count++;
                        $display("%0t: lightness mismatch, expected %0d, actual %0d",
                                 $time, want.light, got.light);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                hsl_expected_q.push_back(predict_hsl(i_s_axis_tdata[CH_W-1:0],
                                                     i_s_axis_tdata[2*CH_W-1:CH_W],
                                                     i_s_axis_tdata[3*CH_W-1:2*CH_W]));
            end
        end
    end

    // output side: random stall before each transaction
    initial begin
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    // drive one pixel and hold it until accepted
    task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - 3 * CH_W){1'b0}}, b, g, r};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // stop sending and wait for every result to come back
    task automatic drain_stream();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (hsl_expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        return CH_W'($urandom_range(0, CH_MAX));
    endfunction

    function automatic logic [CH_W-1:0] edgy_channel();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CH_W'(CH_MAX);
            default: return rand_channel();
        endcase
    endfunction

    // extremes, grays, primaries, ties and the half-lightness boundary
    task automatic test_directed_colors();
        send_pixel(0, 0, 0);
        send_pixel(63, 63, 63);
        send_pixel(31, 31, 31);
        send_pixel(63, 0, 0);
        send_pixel(0, 63, 0);
        send_pixel(0, 0, 63);
        send_pixel(63, 63, 0);
        send_pixel(0, 63, 63);
        send_pixel(63, 0, 63);
        send_pixel(63, 0, 10);
        send_pixel(63, 10, 0);
        send_pixel(62, 0, 0);
        send_pixel(32, 31, 31);
        send_pixel(1, 0, 0);
        send_pixel(0, 1, 0);
        send_pixel(0, 0, 1);
        send_pixel(63, 62, 62);
        send_pixel(62, 63, 63);
        send_pixel(10, 20, 63);
        send_pixel(42, 21, 63);
        send_pixel(21, 42, 0);
    endtask

    // uniform random colors with random idling
    task automatic test_random_colors(input int count);
        repeat (count) send_pixel(rand_channel(), rand_channel(), rand_channel());
    endtask

    // grays, channel ties and colors pinned to the range ends
    task automatic test_corner_colors(input int count);
        logic [CH_W-1:0] a, c;
        repeat (count) begin
            a = edgy_channel();
            c = edgy_channel();
            case ($urandom_range(0, 4))
                0:       send_pixel(a, a, a);
                1:       send_pixel(a, a, c);
                2:       send_pixel(c, a, a);
                3:       send_pixel(a, c, a);
                default: send_pixel(a, c, edgy_channel());
            endcase
        end
    endtask

    // full rate on both sides
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        test_random_colors(count);
        no_idle = 1'b0;
    endtask

    // sender waits for an empty pipeline mid-stream
    task automatic test_drain_pause(input int count);
        test_random_colors(count);
        drain_stream();
        test_random_colors(count);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_colors();
        test_random_colors(250);
        test_drain_pause(30);
        test_back_to_back(120);
        test_corner_colors(150);
        test_random_colors(50);

        drain_stream();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && hsl_expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
